// File: design/tea_pkg.sv
package tea_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned DEFAULT_ROUNDS = 32;
  localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9E37_79B9;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3   = 3'd4;

  typedef struct packed {
    logic [WORD_W-1:0] block_high;
    logic [WORD_W-1:0] block_low;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] result_high;
    logic [WORD_W-1:0] result_low;
  } out_word_t;

  typedef struct packed {
    logic              decrypt_mode;
    logic [WORD_W-1:0] key_word_0;
    logic [WORD_W-1:0] key_word_1;
    logic [WORD_W-1:0] key_word_2;
    logic [WORD_W-1:0] key_word_3;
  } cfg_t;

  // One word in flight between two neighboring cells.
  typedef struct packed {
    logic              valid;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
  } stage_t;

  // The TEA round function.
  function automatic logic [WORD_W-1:0] tea_mix(input logic [WORD_W-1:0] v,
                                                input logic [WORD_W-1:0] sum,
                                                input logic [WORD_W-1:0] ka,
                                                input logic [WORD_W-1:0] kb);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    a = (v << 4) + ka;
    b = v + sum;
    c = (v >> 5) + kb;
    return a ^ b ^ c;
  endfunction

endpackage

// File: design/tea_cfg.sv
module tea_cfg
  import tea_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  output cfg_t                 cfg
);

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DECRYPT_MODE: regs.decrypt_mode <= cfg_data[0];
        REG_KEY_WORD_0:   regs.key_word_0   <= cfg_data;
        REG_KEY_WORD_1:   regs.key_word_1   <= cfg_data;
        REG_KEY_WORD_2:   regs.key_word_2   <= cfg_data;
        REG_KEY_WORD_3:   regs.key_word_3   <= cfg_data;
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

// File: design/tea_cell.sv
module tea_cell
  import tea_pkg::*;
#(
  parameter int unsigned ROUNDS = DEFAULT_ROUNDS,
  parameter int unsigned STEP   = 0
)
(
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  stage_t prev,
  output stage_t next
);

  // Each cell performs one half round. Even steps are the first half of a
  // round, odd steps the second half.
  localparam int unsigned ROUND = STEP / 2;
  localparam bit SECOND_HALF = (STEP % 2) == 1;
  localparam logic [63:0] ENC_PROD = 64'(TEA_DELTA) * 64'(ROUND + 1);
  localparam logic [63:0] DEC_PROD = 64'(TEA_DELTA) * 64'(ROUNDS - ROUND);
  localparam logic [WORD_W-1:0] SUM_ENC = ENC_PROD[WORD_W-1:0];
  localparam logic [WORD_W-1:0] SUM_DEC = DEC_PROD[WORD_W-1:0];

  logic              update_y;
  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] mixed;
  logic [WORD_W-1:0] target;
  logic [WORD_W-1:0] target_next;
  logic              stage_valid;
  logic [WORD_W-1:0] stage_y;
  logic [WORD_W-1:0] stage_z;

  always_comb begin
    // Encryption updates y first, decryption undoes z first.
    update_y    = SECOND_HALF ^ !cfg.decrypt_mode;
    sum         = cfg.decrypt_mode ? SUM_DEC : SUM_ENC;
    if (update_y) begin
      mixed  = tea_mix(prev.z, sum, cfg.key_word_0, cfg.key_word_1);
      target = prev.y;
    end else begin
      mixed  = tea_mix(prev.y, sum, cfg.key_word_2, cfg.key_word_3);
      target = prev.z;
    end
    target_next = cfg.decrypt_mode ? (target - mixed) : (target + mixed);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    stage_y <= update_y ? target_next : prev.y;
    stage_z <= update_y ? prev.z : target_next;
  end

  assign next.valid = stage_valid;
  assign next.y     = stage_y;
  assign next.z     = stage_z;

endmodule

// File: design/tea_block_cipher.sv
// TEA block cipher, fully unrolled into a row of half-round cells.
//
// Input channel: a word (block_high, block_low) is taken at every rising
// clock edge where start is high and busy is low. Busy is high while reset
// is applied and in the cycle after it; after that a new word may be started
// in every cycle.
// Output channel: done pulses for one cycle while result holds the
// processed word. The receiver cannot hold results off, and none is needed:
// results leave in the order words entered, one per cycle at most.
// Each word passes through the row of 2*ROUNDS cells, each of which does
// one half round and registers its output. Throughput is one word per
// clock cycle.
// Configuration: cfg_write with cfg_index and cfg_data writes one register
// (0 decrypt_mode, 1..4 key words 0..3); unused indexes are ignored. Change
// the registers only while no word is in flight, since every cell reads them.
// Synchronous reset clears the registers to zero and drops every word still
// in the row.
module tea_block_cipher
  import tea_pkg::*;
#(
  parameter int unsigned ROUNDS = DEFAULT_ROUNDS
)
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_word_t             block,
  output logic                 done,
  output out_word_t            result,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  localparam int unsigned STEPS = 2 * ROUNDS;

  cfg_t   cfg;
  stage_t chain [0:STEPS];
  logic   accept;

  tea_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The row never stalls, so the only time a word is refused is the
  // cycle right after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign accept = start && !busy;

  assign chain[0].valid = accept;
  assign chain[0].y     = block.block_high;
  assign chain[0].z     = block.block_low;

  for (genvar s = 0; s < STEPS; s++) begin : g_cell
    tea_cell #(
      .ROUNDS (ROUNDS),
      .STEP   (s)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .cfg  (cfg),
      .prev (chain[s]),
      .next (chain[s+1])
    );
  end

  // The last cell's register is the output register.
  assign done               = chain[STEPS].valid;
  assign result.result_high = chain[STEPS].y;
  assign result.result_low  = chain[STEPS].z;

  // Every result comes from an accepted word that passed all 2*ROUNDS cells.
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, STEPS))
    else $error("result without a matching accepted word");

  // Every accepted word leaves the row after passing all 2*ROUNDS cells.
  a_word_not_lost: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##STEPS done)
    else $error("accepted word did not produce a result");

  // Busy is only ever raised by reset.
  a_busy_after_reset: assert property (@(posedge clk)
    !rst |=> !busy)
    else $error("busy high outside the cycle after reset");

endmodule
